[src/svr_pkg.sv]
// ----------------------------------------------------------------------------
// svr_pkg
// Shared widths, register indexes and word types for the strain rotation block.
// ----------------------------------------------------------------------------
package svr_pkg;

    localparam int STRAIN_WIDTH = 32;
    localparam int BASIS_WIDTH  = 18;
    localparam int BFRAC        = BASIS_WIDTH - 2;
    localparam int TSHIFT       = 2 * BFRAC;
    localparam int REG_WIDTH    = 3 * BASIS_WIDTH;
    localparam int IDX_WIDTH    = 3;
    localparam int NUM_COMP     = 6;
    // R entry after rounding, sum of three basis products
    localparam int RW           = BASIS_WIDTH + 3;
    // T entry, products of two R entries plus sum and factor two
    localparam int TW           = 2 * RW + 2;
    // low part of a T entry, multiplied on its own
    localparam int TLO          = TW / 2;
    // product T * v and accumulated sum
    localparam int PW           = TW + STRAIN_WIDTH;
    localparam int AW           = PW + 3;

    localparam logic [IDX_WIDTH-1:0] REG_FROM_ROW0 = 3'd0;
    localparam logic [IDX_WIDTH-1:0] REG_FROM_ROW1 = 3'd1;
    localparam logic [IDX_WIDTH-1:0] REG_FROM_ROW2 = 3'd2;
    localparam logic [IDX_WIDTH-1:0] REG_TO_ROW0   = 3'd3;
    localparam logic [IDX_WIDTH-1:0] REG_TO_ROW1   = 3'd4;
    localparam logic [IDX_WIDTH-1:0] REG_TO_ROW2   = 3'd5;

    typedef logic signed [STRAIN_WIDTH-1:0]        t_strain;
    typedef logic signed [TW-1:0]                  t_tent;
    typedef logic signed [AW-1:0]                  t_acc;
    typedef logic signed [TLO+STRAIN_WIDTH:0]      t_plo;
    typedef logic signed [TW-TLO+STRAIN_WIDTH-1:0] t_phi;

    typedef struct packed {
        t_strain strain_xx;
        t_strain strain_yy;
        t_strain strain_zz;
        t_strain shear_yz;
        t_strain shear_zx;
        t_strain shear_xy;
    } t_in_word;

    typedef struct packed {
        t_strain out_xx;
        t_strain out_yy;
        t_strain out_zz;
        t_strain out_yz;
        t_strain out_zx;
        t_strain out_xy;
        logic    saturated;
    } t_out_word;

endpackage

[src/svr_matrix.sv]
// ----------------------------------------------------------------------------
// svr_matrix
// Holds both bases and derives R and the 6x6 transformation matrix, registered.
// ----------------------------------------------------------------------------
module svr_matrix (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [svr_pkg::IDX_WIDTH-1:0]      i_cfg_idx,
    input  logic [svr_pkg::REG_WIDTH-1:0]      i_cfg_data,
    output svr_pkg::t_tent                     o_t [svr_pkg::NUM_COMP][svr_pkg::NUM_COMP]
);
    import svr_pkg::*;

    localparam logic [REG_WIDTH-1:0] ID0 = REG_WIDTH'(1) << BFRAC;
    localparam logic [REG_WIDTH-1:0] ID1 = REG_WIDTH'(1) << (BFRAC + BASIS_WIDTH);
    localparam logic [REG_WIDTH-1:0] ID2 = REG_WIDTH'(1) << (BFRAC + 2 * BASIS_WIDTH);

    logic [REG_WIDTH-1:0] r_rows [6];
    logic signed [RW-1:0] r_r [3][3];
    logic signed [RW-1:0] n_r [3][3];
    t_tent                r_t [NUM_COMP][NUM_COMP];
    t_tent                n_t [NUM_COMP][NUM_COMP];

    function automatic logic signed [BASIS_WIDTH-1:0] ent(
        input logic [REG_WIDTH-1:0] row, input int c);
        ent = row[c*BASIS_WIDTH +: BASIS_WIDTH];
    endfunction

    function automatic t_tent pr(input logic signed [RW-1:0] a,
                                 input logic signed [RW-1:0] b);
        pr = TW'(a * b);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows[0] <= ID0; r_rows[1] <= ID1; r_rows[2] <= ID2;
            r_rows[3] <= ID0; r_rows[4] <= ID1; r_rows[5] <= ID2;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_FROM_ROW0: r_rows[0] <= i_cfg_data;
                REG_FROM_ROW1: r_rows[1] <= i_cfg_data;
                REG_FROM_ROW2: r_rows[2] <= i_cfg_data;
                REG_TO_ROW0:   r_rows[3] <= i_cfg_data;
                REG_TO_ROW1:   r_rows[4] <= i_cfg_data;
                REG_TO_ROW2:   r_rows[5] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        logic signed [2*BASIS_WIDTH+1:0] s;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                s = '0;
                for (int k = 0; k < 3; k++) begin
                    s = s + (2*BASIS_WIDTH+2)'(ent(r_rows[3+k], i) * ent(r_rows[k], j));
                end
                s = s + ((2*BASIS_WIDTH+2)'(1) <<< (BFRAC - 1));
                n_r[i][j] = RW'(s >>> BFRAC);
            end
        end
    end

    always_comb begin
        logic signed [RW-1:0] a [3][3];
        a = r_r;
        for (int c = 0; c < 3; c++) begin
            for (int j = 0; j < 3; j++) begin
                n_t[c][j] = pr(a[c][j], a[c][j]);
            end
            n_t[c][3] = pr(a[c][1], a[c][2]);
            n_t[c][4] = pr(a[c][0], a[c][2]);
            n_t[c][5] = pr(a[c][0], a[c][1]);
        end
        // shear rows: (1,2) -> yz, (0,2) -> zx, (0,1) -> xy
        for (int s = 0; s < 3; s++) begin
            int p, q;
            p = (s == 0) ? 1 : 0;
            q = (s == 2) ? 1 : 2;
            for (int j = 0; j < 3; j++) begin
                n_t[3+s][j] = pr(a[p][j], a[q][j]) <<< 1;
            end
            n_t[3+s][3] = pr(a[p][1], a[q][2]) + pr(a[p][2], a[q][1]);
            n_t[3+s][4] = pr(a[p][0], a[q][2]) + pr(a[p][2], a[q][0]);
            n_t[3+s][5] = pr(a[p][0], a[q][1]) + pr(a[p][1], a[q][0]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_r <= n_r;
        r_t <= n_t;
    end

    assign o_t = r_t;

endmodule

[src/svr_cell.sv]
// ----------------------------------------------------------------------------
// svr_cell
// One cell of the chain: multiplies one strain component by its T column in
// two halves and adds it to the six running sums handed on from the previous
// cell, over two register stages.
// ----------------------------------------------------------------------------
module svr_cell (
    input  logic             i_clk,
    input  logic             i_en,
    input  svr_pkg::t_strain i_v,
    input  svr_pkg::t_tent   i_tcol [svr_pkg::NUM_COMP],
    input  svr_pkg::t_acc    i_acc  [svr_pkg::NUM_COMP],
    input  svr_pkg::t_in_word i_word,
    output svr_pkg::t_acc    o_acc  [svr_pkg::NUM_COMP],
    output svr_pkg::t_in_word o_word
);
    import svr_pkg::*;

    t_plo     r_plo [NUM_COMP];
    t_phi     r_phi [NUM_COMP];
    t_acc     r_acc_in [NUM_COMP];
    t_in_word r_word_in;
    t_acc     r_acc [NUM_COMP];
    t_in_word r_word;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < NUM_COMP; i++) begin
                r_plo[i]    <= $signed({1'b0, i_tcol[i][TLO-1:0]}) * i_v;
                r_phi[i]    <= $signed(i_tcol[i][TW-1:TLO]) * i_v;
                r_acc_in[i] <= i_acc[i];
                r_acc[i]    <= r_acc_in[i] + AW'(r_plo[i]) + (AW'(r_phi[i]) <<< TLO);
            end
            r_word_in <= i_word;
            r_word    <= r_word_in;
        end
    end

    assign o_acc  = r_acc;
    assign o_word = r_word;

endmodule

[src/strain_voigt_rotation.sv]
// ----------------------------------------------------------------------------
// strain_voigt_rotation
// Voigt strain rotation between two configured orthonormal bases.
// ----------------------------------------------------------------------------
// One strain word is accepted per cycle while o_ready is high. A chain of six
// cells, each two register stages deep, folds in one input component per
// cell, and a last stage rounds and saturates. The whole chain advances when
// the output register is free or taken, so a stalled output holds everything
// in place. The transformation matrix is derived from the basis registers
// over two register stages, so input is held off after reset and after every
// configuration write until it has settled; write configuration only while
// the block is idle.
module strain_voigt_rotation (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [svr_pkg::IDX_WIDTH-1:0] i_cfg_idx,
    input  logic [svr_pkg::REG_WIDTH-1:0] i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  svr_pkg::t_in_word             i_data,
    output logic                          o_valid,
    input  logic                          i_ready,
    output svr_pkg::t_out_word            o_data
);
    import svr_pkg::*;

    localparam int NST = 2 * NUM_COMP + 1;
    localparam logic signed [AW-1:0] RBIAS = AW'(1) <<< (TSHIFT - 1);
    localparam logic signed [AW-TSHIFT-1:0] MAXV = (AW-TSHIFT)'((64'(1) << (STRAIN_WIDTH-1)) - 1);
    localparam logic signed [AW-TSHIFT-1:0] MINV = -(AW-TSHIFT)'(64'(1) << (STRAIN_WIDTH-1));

    t_tent     w_t [NUM_COMP][NUM_COMP];
    t_tent     w_col [NUM_COMP][NUM_COMP];
    t_acc      w_acc [NUM_COMP+1][NUM_COMP];
    t_in_word  w_word [NUM_COMP+1];
    t_strain   w_v [NUM_COMP];
    logic      [NST-1:0] r_vld;
    logic      [1:0] r_cfg_hold;
    logic      w_adv;
    t_out_word r_out;
    t_out_word n_out;

    svr_matrix u_matrix (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_t        (w_t)
    );

    assign w_adv   = !r_vld[NST-1] || i_ready;
    assign o_ready = w_adv && (r_cfg_hold == 2'b00);

    assign w_word[0] = i_data;
    assign w_acc[0]  = '{default: RBIAS};

    always_comb begin
        for (int c = 0; c < NUM_COMP; c++) begin
            for (int i = 0; i < NUM_COMP; i++) begin
                w_col[c][i] = w_t[i][c];
            end
        end
        w_v[0] = w_word[0].strain_xx;
        w_v[1] = w_word[1].strain_yy;
        w_v[2] = w_word[2].strain_zz;
        w_v[3] = w_word[3].shear_yz;
        w_v[4] = w_word[4].shear_zx;
        w_v[5] = w_word[5].shear_xy;
    end

    for (genvar c = 0; c < NUM_COMP; c++) begin : g_cell
        svr_cell u_cell (
            .i_clk  (i_clk),
            .i_en   (w_adv),
            .i_v    (w_v[c]),
            .i_tcol (w_col[c]),
            .i_acc  (w_acc[c]),
            .i_word (w_word[c]),
            .o_acc  (w_acc[c+1]),
            .o_word (w_word[c+1])
        );
    end

    always_comb begin
        logic signed [AW-TSHIFT-1:0] q;
        t_strain res [NUM_COMP];
        logic sat;
        sat = 1'b0;
        for (int i = 0; i < NUM_COMP; i++) begin
            q = (AW-TSHIFT)'(w_acc[NUM_COMP][i] >>> TSHIFT);
            if (q > MAXV) begin
                res[i] = STRAIN_WIDTH'(MAXV);
                sat = 1'b1;
            end else if (q < MINV) begin
                res[i] = STRAIN_WIDTH'(MINV);
                sat = 1'b1;
            end else begin
                res[i] = STRAIN_WIDTH'(q);
            end
        end
        n_out = '{res[0], res[1], res[2], res[3], res[4], res[5], sat};
    end

    // hold off input until the matrix has settled after reset or a write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_hold <= 2'b11;
        end else if (i_cfg_we) begin
            r_cfg_hold <= 2'b11;
        end else begin
            r_cfg_hold <= {1'b0, r_cfg_hold[1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[NST-2:0], i_valid && o_ready};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_vld[NST-1];
    assign o_data  = r_out;

endmodule
